// ===== hw/rtl/backing_store_map_table_assert.svh =====
// Assertion helpers for the RTL files; included by bsmt_ctrl.
`ifndef BACKING_STORE_MAP_TABLE_ASSERT_SVH
`define BACKING_STORE_MAP_TABLE_ASSERT_SVH

// Clocked property, masked while reset is asserted.
`define BSMT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true at a clock edge.
`define BSMT_ASSERT_NEVER(name, cond, msg) \
  `BSMT_ASSERT(name, !(cond), msg)

`endif

// ===== hw/rtl/bsmt_pkg.sv =====
`default_nettype none
package bsmt_pkg;

  // Default configuration
  localparam int unsigned NUM_STORES_DEF = 16;
  localparam int unsigned NUM_PROCS_DEF  = 64;
  localparam int unsigned MAX_PAGES_DEF  = 128;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_MAP    = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [5:0]  pid;
    logic [3:0]  store;
    logic [19:0] vpno;
    logic [7:0]  npages;
    logic [31:0] vaddr;
  } req_t;

  typedef struct packed {
    logic       status;
    logic       found;
    logic [3:0] store_index;
    logic [6:0] page_offset;
  } rsp_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, scan table, read page memories
    logic commit;   // update table, load result register
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bsmt_ctrl.sv =====
`default_nettype none
`include "backing_store_map_table_assert.svh"
module bsmt_ctrl
  import bsmt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.commit = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BSMT_ASSERT(a_capture_evals, cmd_o.capture |=> state_q == ST_EVAL, "capture lost")
  `BSMT_ASSERT(a_commit_shows, cmd_o.commit |=> out_valid_q && state_q == ST_IDLE, "commit lost")
  `BSMT_ASSERT(a_stall_holds, state_q == ST_EVAL && out_valid_q && !out_ready_i |=> state_q == ST_EVAL, "left evaluation while result pending")
  `BSMT_ASSERT_NEVER(a_no_overwrite, cmd_o.commit && out_valid_q && !out_ready_i, "result overwritten")

endmodule
`default_nettype wire

// ===== hw/rtl/bsmt_dp.sv =====
`default_nettype none
module bsmt_dp
  import bsmt_pkg::*;
#(
  parameter int unsigned NUM_STORES = NUM_STORES_DEF,
  parameter int unsigned NUM_PROCS  = NUM_PROCS_DEF,
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire req_t req_i,
  output rsp_t      rsp_o
);

  localparam int unsigned SW  = $clog2(NUM_STORES);
  localparam int unsigned PIW = $clog2(NUM_PROCS);
  localparam int unsigned PGW = 32 - PAGE_SHIFT;
  localparam int unsigned CW  = (PGW > 21) ? PGW : 21;

  // Table state
  logic                 mapped_q [NUM_STORES];
  logic [NUM_PROCS-1:0] sharer_q [NUM_STORES];
  logic [7:0]           cnt_mem  [NUM_STORES];
  logic [19:0]          base_mem [NUM_STORES];

  // Request and scan results held across evaluation
  req_t          req_q;
  logic          alloc_ok_q, look_hit_q;
  logic [SW-1:0] alloc_idx_q, look_idx_q;
  logic [7:0]    cnt_rd_q;
  logic [19:0]   base_rd_q;
  rsp_t          rsp_q, rsp_d;

  // Scan against the incoming request
  logic [6:0]     in_st_ext, in_pid_ext;
  logic [PIW-1:0] in_pid_idx;
  logic           in_pid_ok;
  logic           alloc_ok, look_hit;
  logic [SW-1:0]  alloc_idx, look_idx, rd_addr;

  assign in_st_ext  = 7'(req_i.store);
  assign in_pid_ext = 7'(req_i.pid);
  assign in_pid_idx = in_pid_ext[PIW-1:0];
  assign in_pid_ok  = in_pid_ext < 7'(NUM_PROCS);

  always_comb begin
    alloc_ok  = 1'b0;
    alloc_idx = '0;
    look_hit  = 1'b0;
    look_idx  = '0;
    for (int i = NUM_STORES - 1; i >= 0; i--) begin
      if (!mapped_q[i]) begin
        alloc_ok  = 1'b1;
        alloc_idx = SW'(i);
      end
      if (in_pid_ok && sharer_q[i][in_pid_idx]) begin
        look_hit = 1'b1;
        look_idx = SW'(i);
      end
    end
  end

  assign rd_addr = (req_i.mode == MODE_MAP) ? in_st_ext[SW-1:0] : look_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q       <= req_i;
      alloc_ok_q  <= alloc_ok;
      alloc_idx_q <= alloc_idx;
      look_hit_q  <= look_hit;
      look_idx_q  <= look_idx;
      cnt_rd_q    <= cnt_mem[rd_addr];
      base_rd_q   <= base_mem[rd_addr];
    end
  end

  // Evaluation of the held request
  logic [6:0]     st_ext, pid_ext;
  logic [SW-1:0]  st_idx;
  logic [PIW-1:0] pid_idx;
  logic           st_ok, pid_ok, np_ok;
  logic           map_ok, join_ok, claim;
  logic           free_we, map_we, cnt_we;
  logic [CW-1:0]  page, base_ext, top, diff;

  assign st_ext  = 7'(req_q.store);
  assign pid_ext = 7'(req_q.pid);
  assign st_idx  = st_ext[SW-1:0];
  assign pid_idx = pid_ext[PIW-1:0];
  assign st_ok   = st_ext < 7'(NUM_STORES);
  assign pid_ok  = pid_ext < 7'(NUM_PROCS);
  assign np_ok   = (req_q.npages != 8'd0) && (9'(req_q.npages) <= 9'(MAX_PAGES));

  assign map_ok  = st_ok && pid_ok && np_ok;
  assign claim   = map_ok && !mapped_q[st_idx];
  assign join_ok = map_ok && mapped_q[st_idx] && !sharer_q[st_idx][pid_idx]
                   && (cnt_rd_q >= req_q.npages);

  assign page     = CW'(req_q.vaddr[31:PAGE_SHIFT]);
  assign base_ext = CW'(base_rd_q);
  assign top      = base_ext + CW'(cnt_rd_q);
  assign diff     = page - base_ext;

  always_comb begin
    rsp_d = '{status: STATUS_OK, found: 1'b0, store_index: 4'd0, page_offset: 7'd0};
    case (req_q.mode)
      MODE_ALLOC: begin
        rsp_d.status = alloc_ok_q ? STATUS_OK : STATUS_ERR;
        rsp_d.found  = alloc_ok_q;
        if (alloc_ok_q) rsp_d.store_index = 4'(alloc_idx_q);
      end
      MODE_FREE: begin
        if (!st_ok) rsp_d.status = STATUS_ERR;
      end
      MODE_MAP: begin
        if (!(claim || join_ok)) rsp_d.status = STATUS_ERR;
      end
      MODE_LOOKUP: begin
        if (look_hit_q) begin
          if (page < base_ext || page >= top) begin
            rsp_d.status = STATUS_ERR;
          end else begin
            rsp_d.found       = 1'b1;
            rsp_d.store_index = 4'(look_idx_q);
            rsp_d.page_offset = 7'(diff);
          end
        end
      end
      default: rsp_d.status = STATUS_ERR;
    endcase
  end

  assign free_we = cmd_i.commit && (req_q.mode == MODE_FREE) && st_ok;
  assign map_we  = cmd_i.commit && (req_q.mode == MODE_MAP) && (claim || join_ok);
  assign cnt_we  = cmd_i.commit && (req_q.mode == MODE_MAP) && claim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STORES; i++) begin
        mapped_q[i] <= 1'b0;
        sharer_q[i] <= '0;
      end
    end else if (free_we) begin
      mapped_q[st_idx] <= 1'b0;
      sharer_q[st_idx] <= '0;
    end else if (map_we) begin
      mapped_q[st_idx]          <= 1'b1;
      sharer_q[st_idx][pid_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) base_mem[st_idx] <= req_q.vpno;
    if (cnt_we) cnt_mem[st_idx]  <= req_q.npages;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

// ===== hw/rtl/backing_store_map_table.sv =====
// Channel   Direction  Handshake                  Payload
// request   in         in_valid_i / in_ready_o    in_req_i  (bsmt_pkg::req_t)
// result    out        out_valid_o / out_ready_i  out_rsp_o (bsmt_pkg::rsp_t)
//
// A request is accepted in idle, where the table flags are scanned and the page
// count and base memories are read; it is then evaluated, and committed once
// the result register is free. Those memories have a single read port.
// Reset clears all mapped flags and sharer bitmaps at once; no clearing pass.
// A result held by a stalled consumer blocks only the commit of the next
// request, which waits in evaluation until the result register frees up.
`default_nettype none
module backing_store_map_table
  import bsmt_pkg::*;
#(
  parameter int unsigned NUM_STORES = NUM_STORES_DEF,
  parameter int unsigned NUM_PROCS  = NUM_PROCS_DEF,
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  // Commands from the sequencer: capture on request accept, commit once
  // the result register can take the new result.
  cmd_t cmd;

  // Sequencer: owns both handshakes and the result-valid flag.
  bsmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: flag and sharer arrays, page memories, priority scans,
  // range check and the result register.
  bsmt_dp #(
    .NUM_STORES (NUM_STORES),
    .NUM_PROCS  (NUM_PROCS),
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule
`default_nettype wire
